FILE: design/zsn_pkg.sv
// Shared types and constants of the z-score sample normalizer.
`default_nettype none
package zsn_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 23;
  localparam int SQS_W      = 37;
  localparam int DIV_W      = 37;
  localparam int DVSR_W     = 16;
  localparam int NORM_SHIFT = 11;
  localparam int SHORT_STEPS = 28;
  localparam int IDX_W      = 6;
  localparam int ROOT_W     = 19;

  typedef enum logic [1:0] {
    DIV_MEAN = 2'd0,
    DIV_VAR  = 2'd1,
    DIV_NORM = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     latch_mean;
    logic     latch_msq;
    logic     latch_var;
    logic     sqrt_start;
    logic     latch_dev;
    logic     rd_req;
    logic     latch_norm;
    logic     latch_out;
    logic     advance;
    logic     clear;
  } zsn_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic zero_dev;
    logic last_k;
  } zsn_stat_t;

endpackage
`default_nettype wire

FILE: design/zsn_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module zsn_ram #(
  parameter int W = 16,
  parameter int D = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: design/zsn_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module zsn_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic                       short_mode,
  input  wire logic [zsn_pkg::DIV_W-1:0]  dividend,
  input  wire logic [zsn_pkg::DVSR_W-1:0] divisor,
  output logic      [zsn_pkg::DIV_W-1:0]  quotient,
  output logic                            done
);
  import zsn_pkg::*;

  logic [DIV_W-1:0]  q_r, q_nxt;
  logic [DVSR_W-1:0] rem_r, rem_nxt, dvsr_r;
  logic [5:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [DVSR_W:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem_r, q_r[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dvsr_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = short_mode ? {dividend[SHORT_STEPS-1:0], (DIV_W-SHORT_STEPS)'(0)}
                            : dividend;
      rem_nxt  = '0;
      cnt_nxt  = short_mode ? 6'(SHORT_STEPS) : 6'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[DIV_W-2:0], fits};
      rem_nxt = fits ? DVSR_W'(rem_sh - {1'b0, dvsr_r}) : rem_sh[DVSR_W-1:0];
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvsr_r <= divisor;
    end
  end

  assign quotient = q_r;
  assign done     = done_r;
endmodule
`default_nettype wire

FILE: design/zsn_sqrt.sv
// Bit-pair integer square root, one root bit per cycle.
`default_nettype none
module zsn_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [zsn_pkg::SQS_W-1:0]  radicand,
  output logic      [zsn_pkg::ROOT_W-1:0] root,
  output logic                            done
);
  import zsn_pkg::*;

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt, rem_sh, trial;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_comb begin
    rad_nxt  = rad_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = RAD_W'(radicand);
      root_nxt = '0;
      rem_nxt  = '0;
      cnt_nxt  = 5'(ROOT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
  end

  assign root = root_r;
  assign done = done_r;
endmodule
`default_nettype wire

FILE: design/zsn_ctrl.sv
// Sequencer of the normalizer: load, statistics, per-sample emit.
`default_nettype none
module zsn_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire logic               in_tlast,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  input  wire zsn_pkg::zsn_stat_t stat,
  output zsn_pkg::zsn_cmd_t       cmd
);
  import zsn_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_MEAN_GO = 11'b00000000010,
    S_MEAN_W  = 11'b00000000100,
    S_VAR_GO  = 11'b00000001000,
    S_VAR_W   = 11'b00000010000,
    S_SQRT_GO = 11'b00000100000,
    S_SQRT_W  = 11'b00001000000,
    S_RD      = 11'b00010000000,
    S_NORM_GO = 11'b00100000000,
    S_NORM_W  = 11'b01000000000,
    S_OUT     = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.div_sel = DIV_MEAN;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_tlast) begin
            state_nxt = S_MEAN_GO;
          end
        end
      end
      S_MEAN_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_MEAN_W;
      end
      S_MEAN_W: begin
        if (stat.div_done) begin
          cmd.latch_mean = 1'b1;
          state_nxt      = S_VAR_GO;
        end
      end
      S_VAR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_VAR;
        cmd.latch_msq = 1'b1;
        state_nxt     = S_VAR_W;
      end
      S_VAR_W: begin
        if (stat.div_done) begin
          cmd.latch_var = 1'b1;
          state_nxt     = S_SQRT_GO;
        end
      end
      S_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = S_SQRT_W;
      end
      S_SQRT_W: begin
        if (stat.sqrt_done) begin
          cmd.latch_dev = 1'b1;
          state_nxt     = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_req = 1'b1;
        state_nxt  = S_NORM_GO;
      end
      S_NORM_GO: begin
        cmd.latch_norm = 1'b1;
        cmd.div_sel    = DIV_NORM;
        if (stat.zero_dev) begin
          cmd.latch_out = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_NORM_W;
        end
      end
      S_NORM_W: begin
        cmd.div_sel = DIV_NORM;
        if (stat.div_done) begin
          cmd.latch_out = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (stat.last_k) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: design/zsn_datapath.sv
// Datapath: sample store, running sums, statistics and result registers.
`default_nettype none
module zsn_datapath #(
  parameter int MAX_SAMPLES = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire zsn_pkg::zsn_cmd_t            cmd,
  output zsn_pkg::zsn_stat_t                stat,
  input  wire logic [zsn_pkg::SAMPLE_W-1:0] sample_value,
  output logic      [zsn_pkg::SAMPLE_W-1:0] normalized_value,
  output logic      [zsn_pkg::IDX_W-1:0]    sample_index,
  output logic                              last_result,
  output logic                              zero_spread
);
  import zsn_pkg::*;

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  logic [CW-1:0]         count_r;
  logic [AW-1:0]         k_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQS_W-1:0]      sqs_r;
  logic [SAMPLE_W-1:0]   mean_r, dev_r, out_val_r;
  logic [2*SAMPLE_W-1:0] msq_r;
  logic [SQS_W-1:0]      var_r;
  logic                  norm_neg_r;
  logic                  full;
  logic signed [2*SAMPLE_W-1:0] sq;
  logic signed [SAMPLE_W-1:0]   mean_s;
  logic signed [2*SAMPLE_W-1:0] msq_prod;
  logic [SAMPLE_W-1:0]   rdata;
  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0]     abs_diff;
  logic [SUM_W-1:0]      abs_sum;
  logic [DIV_W-1:0]      dividend, quot;
  logic [DVSR_W-1:0]     divisor;
  logic [ROOT_W-1:0]     root;
  logic [SAMPLE_W-1:0]   q_mean, sat_val;
  logic                  div_done, sqrt_done;

  assign full = count_r == CW'(MAX_SAMPLES);
  assign sq   = $signed(sample_value) * $signed(sample_value);

  // Full-width square of the mean.
  assign mean_s   = mean_r;
  assign msq_prod = mean_s * mean_s;

  zsn_ram #(.W(SAMPLE_W), .D(MAX_SAMPLES)) u_store (
    .clk   (clk),
    .we    (cmd.load && !full),
    .waddr (count_r[AW-1:0]),
    .wdata (sample_value),
    .re    (cmd.rd_req),
    .raddr (k_r),
    .rdata (rdata)
  );

  assign diff     = $signed({rdata[SAMPLE_W-1], rdata}) - $signed({mean_r[SAMPLE_W-1], mean_r});
  assign abs_diff = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;
  assign abs_sum  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : sum_r;

  always_comb begin
    case (cmd.div_sel)
      DIV_MEAN: begin
        dividend = DIV_W'(abs_sum);
        divisor  = DVSR_W'(count_r);
      end
      DIV_VAR: begin
        dividend = sqs_r;
        divisor  = DVSR_W'(count_r);
      end
      DIV_NORM: begin
        dividend = DIV_W'({abs_diff, NORM_SHIFT'(0)});
        divisor  = dev_r;
      end
      default: begin
        dividend = '0;
        divisor  = '0;
      end
    endcase
  end

  zsn_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cmd.div_start),
    .short_mode (cmd.div_sel == DIV_NORM),
    .dividend   (dividend),
    .divisor    (divisor),
    .quotient   (quot),
    .done       (div_done)
  );

  zsn_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (var_r),
    .root     (root),
    .done     (sqrt_done)
  );

  assign q_mean = sum_r[SUM_W-1] ? SAMPLE_W'(-quot[SAMPLE_W-1:0]) : quot[SAMPLE_W-1:0];

  // Saturate the magnitude quotient into signed Q4.11.
  always_comb begin
    if (norm_neg_r) begin
      sat_val = (quot > DIV_W'(32768)) ? 16'h8000 : SAMPLE_W'(-quot[SAMPLE_W-1:0]);
    end else begin
      sat_val = (quot > DIV_W'(32767)) ? 16'h7FFF : quot[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      sqs_r   <= '0;
      k_r     <= '0;
      mean_r  <= '0;
      dev_r   <= '0;
    end else begin
      if (cmd.load && !full) begin
        count_r <= count_r + CW'(1);
        sum_r   <= sum_r + SUM_W'($signed(sample_value));
        sqs_r   <= sqs_r + SQS_W'($unsigned(sq));
      end
      if (cmd.latch_mean) begin
        mean_r <= q_mean;
      end
      if (cmd.latch_dev) begin
        dev_r <= root[SAMPLE_W-1:0];
      end
      if (cmd.advance) begin
        k_r <= k_r + AW'(1);
      end
      if (cmd.clear) begin
        count_r <= '0;
        sum_r   <= '0;
        sqs_r   <= '0;
        k_r     <= '0;
      end
    end
    if (cmd.latch_msq) begin
      msq_r <= $unsigned(msq_prod);
    end
    if (cmd.latch_var) begin
      var_r <= (quot > SQS_W'(msq_r)) ? quot - SQS_W'(msq_r) : '0;
    end
    if (cmd.latch_norm) begin
      norm_neg_r <= diff[SAMPLE_W];
    end
    if (cmd.latch_out) begin
      out_val_r <= (dev_r == '0) ? '0 : sat_val;
    end
  end

  assign stat.div_done  = div_done;
  assign stat.sqrt_done = sqrt_done;
  assign stat.zero_dev  = dev_r == '0;
  assign stat.last_k    = (CW'(k_r) + CW'(1)) == count_r;

  assign normalized_value = out_val_r;
  assign sample_index     = IDX_W'(k_r);
  assign last_result      = stat.last_k;
  assign zero_spread      = stat.zero_dev;
endmodule
`default_nettype wire

FILE: design/zscore_sample_normalizer_top.sv
// Top level of the z-score sample normalizer.
`default_nettype none
// Collects signed Q8.8 samples, one per input transfer, into a store of
// MAX_SAMPLES entries while keeping running sum and sum of squares; samples
// that arrive with the store full are dropped. The transfer with in_tlast set
// closes the set: mean (sum/n, truncated), variance (sum2/n - mean^2, clamped
// at zero) and deviation (floor square root) are computed, then every held
// sample leaves in order as (sample - mean) * 2048 / deviation in signed Q4.11,
// truncated and saturated, with its index, out_tlast on the final one and
// out_tuser set when the deviation is zero (values then read zero).
// While a set loads, in_tready stays high. Closing a set runs the mean
// divide, the variance divide and the square root in turn, then each result
// takes a store read and a pass through the shared one-bit-per-cycle
// divider (skipped when the deviation is zero) and waits out any output stall.
// One set is handled at a time; input is held off until the last result is
// taken.
module zscore_sample_normalizer_top #(
  parameter int MAX_SAMPLES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] sample_value
  input  wire logic        in_tlast,   // last_sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [15:0] normalized_value, [21:16] sample_index
  output logic             out_tlast,  // last_result
  output logic [0:0]       out_tuser   // [0] zero_spread
);
  import zsn_pkg::*;

  zsn_cmd_t            cmd;
  zsn_stat_t           stat;
  logic [SAMPLE_W-1:0] norm_val;
  logic [IDX_W-1:0]    idx;
  logic                last_res, zero_sp;

  // Sequence the load, statistics and emit phases.
  zsn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Hold samples, sums, statistics and the pending result.
  zsn_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .sample_value     (in_tdata),
    .normalized_value (norm_val),
    .sample_index     (idx),
    .last_result      (last_res),
    .zero_spread      (zero_sp)
  );

  assign out_tdata = {2'b00, idx, norm_val};
  assign out_tlast = last_res;
  assign out_tuser = zero_sp;
endmodule
`default_nettype wire
